### hdl/rig_pkg.sv
// rig_pkg: types, constants and character helpers for the random identifier generator
// used by rig_arith and random_id_string_generator_core; no dependencies
package rig_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELECT,
        ST_UPDATE,
        ST_MUL_RECIP,
        ST_REMAINDER,
        ST_OUTPUT
    } state_t;

    typedef enum logic [1:0] {
        KIND_PREFIX,
        KIND_DIGIT,
        KIND_DASH,
        KIND_ALNUM
    } kind_t;

    typedef struct packed {
        logic mul_en;
        logic recip;
        logic digit;
    } arith_ctrl_t;

    localparam logic OP_MIX      = 1'b0;
    localparam logic OP_GENERATE = 1'b1;

    localparam logic [31:0] SEED_RESET = 32'h0000_ACE1;
    localparam logic [31:0] LCG_MUL    = 32'd1103515245;
    localparam logic [31:0] LCG_ADD    = 32'd12345;

    // ceil(2^35 / d) for the reciprocal divide
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP_36    = 32'h38E3_8E39;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [31:0] MOD_DIGIT = 32'd10;
    localparam logic [31:0] MOD_ALNUM = 32'd36;

    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h61;
    localparam logic [7:0] CHAR_D    = 8'h64;
    localparam logic [7:0] CHAR_L    = 8'h6C;
    localparam logic [7:0] CHAR_M    = 8'h6D;

    function automatic logic [7:0] prefix_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CHAR_L;
            2'd1:    ch = CHAR_D;
            2'd2:    ch = CHAR_M;
            default: ch = CHAR_M;
        endcase
        return ch;
    endfunction

    // a-z then 0-9
    function automatic logic [7:0] alnum_char(input logic [5:0] idx);
        logic [7:0] ch;
        if (idx < 6'd26) begin
            ch = CHAR_A + {2'b00, idx};
        end else begin
            ch = CHAR_ZERO + {2'b00, idx} - 8'd26;
        end
        return ch;
    endfunction

endpackage

### hdl/rig_arith.sv
// rig_arith: shared 32x32 multiplier with product register, seed update sum and
// reciprocal-based remainder by 10 or 36; depends on rig_pkg
module rig_arith (
    input  logic                 aclk,
    input  rig_pkg::arith_ctrl_t ctrl,
    input  logic [31:0]          operand,
    output logic [31:0]          lcg_value,
    output logic [5:0]           remainder
);

    logic [63:0] prod_reg;
    logic        digit_reg;
    logic [31:0] mult;
    logic [28:0] quot;
    logic [34:0] quot_times_d;
    logic [31:0] rem_raw;
    logic [31:0] modulus;
    logic [31:0] rem_fix;

    always_comb begin
        if (ctrl.recip) begin
            mult = ctrl.digit ? rig_pkg::RECIP_10 : rig_pkg::RECIP_36;
        end else begin
            mult = rig_pkg::LCG_MUL;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg  <= {32'd0, operand} * {32'd0, mult};
            digit_reg <= ctrl.digit;
        end
    end

    assign lcg_value = prod_reg[31:0] + rig_pkg::LCG_ADD;

    // quotient estimate, then one compare and subtract
    assign quot = prod_reg[63:rig_pkg::RECIP_SHIFT];

    always_comb begin
        if (digit_reg) begin
            quot_times_d = {3'b000, quot, 3'b000} + {5'b00000, quot, 1'b0};
            modulus      = rig_pkg::MOD_DIGIT;
        end else begin
            quot_times_d = {1'b0, quot, 5'b00000} + {4'b0000, quot, 2'b00};
            modulus      = rig_pkg::MOD_ALNUM;
        end
        rem_raw = operand - quot_times_d[31:0];
        rem_fix = (rem_raw >= modulus) ? rem_raw - modulus : rem_raw;
    end

    assign remainder = rem_fix[5:0];

endmodule

### hdl/random_id_string_generator_core.sv
// random_id_string_generator_core: top level of the identifier string generator
// holds the seed, position sequencer and output register; uses rig_pkg and rig_arith
//
// channel  dir  tdata               tuser         tlast
// s_       in   [31:0] entropy      [0] operation -
// m_       out  [7:0]  character    -             final character
//
// a mix item is applied to the seed in the idle state; a generate item runs one
// character at a time; prefix and dash characters go from select to output, generated
// ones through select, update, reciprocal multiply, remainder and output (two passes
// through the shared multiplier); a stall holds the sequencer in the output state
// s_tready is high only while idle; reset sets the seed to its start value
module random_id_string_generator_core #(
    parameter int DIGIT_COUNT  = 4,
    parameter int GROUP_LENGTH = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] entropy
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] character
    output logic        m_tlast
);

    localparam int ID_LENGTH = 5 + DIGIT_COUNT + 2 * GROUP_LENGTH;
    localparam int POS_W     = $clog2(ID_LENGTH);

    localparam logic [POS_W-1:0] DIGIT_START = POS_W'(3);
    localparam logic [POS_W-1:0] DASH_FIRST  = POS_W'(3 + DIGIT_COUNT);
    localparam logic [POS_W-1:0] DASH_SECOND = POS_W'(4 + DIGIT_COUNT + GROUP_LENGTH);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(ID_LENGTH - 1);

    rig_pkg::state_t      state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [31:0]          seed_reg, seed_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [7:0]           m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;
    rig_pkg::kind_t       kind;
    rig_pkg::arith_ctrl_t arith_ctrl;
    logic [31:0]          lcg_value;
    logic [5:0]           remainder;

    rig_arith u_arith (
        .aclk      (aclk),
        .ctrl      (arith_ctrl),
        .operand   (seed_reg),
        .lcg_value (lcg_value),
        .remainder (remainder)
    );

    always_comb begin
        if (pos_reg < DIGIT_START) begin
            kind = rig_pkg::KIND_PREFIX;
        end else if (pos_reg < DASH_FIRST) begin
            kind = rig_pkg::KIND_DIGIT;
        end else if (pos_reg == DASH_FIRST || pos_reg == DASH_SECOND) begin
            kind = rig_pkg::KIND_DASH;
        end else begin
            kind = rig_pkg::KIND_ALNUM;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rig_pkg::ST_IDLE;
            pos_reg      <= '0;
            seed_reg     <= rig_pkg::SEED_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            seed_reg     <= seed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        seed_next     = seed_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        arith_ctrl    = '0;
        s_tready      = 1'b0;

        case (state_reg)
            rig_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == rig_pkg::OP_GENERATE) begin
                        pos_next   = '0;
                        state_next = rig_pkg::ST_SELECT;
                    end else begin
                        seed_next = seed_reg ^ s_tdata;
                    end
                end
            end
            rig_pkg::ST_SELECT: begin
                case (kind)
                    rig_pkg::KIND_PREFIX: begin
                        m_tdata_next  = rig_pkg::prefix_char(pos_reg[1:0]);
                        m_tlast_next  = (pos_reg == POS_LAST);
                        m_tvalid_next = 1'b1;
                        state_next    = rig_pkg::ST_OUTPUT;
                    end
                    rig_pkg::KIND_DASH: begin
                        m_tdata_next  = rig_pkg::CHAR_DASH;
                        m_tlast_next  = (pos_reg == POS_LAST);
                        m_tvalid_next = 1'b1;
                        state_next    = rig_pkg::ST_OUTPUT;
                    end
                    default: begin
                        arith_ctrl.mul_en = 1'b1;
                        state_next        = rig_pkg::ST_UPDATE;
                    end
                endcase
            end
            rig_pkg::ST_UPDATE: begin
                seed_next  = lcg_value;
                state_next = rig_pkg::ST_MUL_RECIP;
            end
            rig_pkg::ST_MUL_RECIP: begin
                arith_ctrl.mul_en = 1'b1;
                arith_ctrl.recip  = 1'b1;
                arith_ctrl.digit  = (kind == rig_pkg::KIND_DIGIT);
                state_next        = rig_pkg::ST_REMAINDER;
            end
            rig_pkg::ST_REMAINDER: begin
                if (kind == rig_pkg::KIND_DIGIT) begin
                    m_tdata_next = rig_pkg::CHAR_ZERO + {2'b00, remainder};
                end else begin
                    m_tdata_next = rig_pkg::alnum_char(remainder);
                end
                m_tlast_next  = (pos_reg == POS_LAST);
                m_tvalid_next = 1'b1;
                state_next    = rig_pkg::ST_OUTPUT;
            end
            rig_pkg::ST_OUTPUT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (pos_reg == POS_LAST) begin
                        state_next = rig_pkg::ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + POS_W'(1);
                        state_next = rig_pkg::ST_SELECT;
                    end
                end
            end
            default: begin
                state_next = rig_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == rig_pkg::ST_OUTPUT))
        else $error("result valid outside output state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rig_pkg::ST_REMAINDER) |->
            ((kind == rig_pkg::KIND_DIGIT) ? (remainder < 6'd10) : (remainder < 6'd36)))
        else $error("remainder out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == rig_pkg::OP_GENERATE) |=>
            (state_reg == rig_pkg::ST_SELECT && pos_reg == '0))
        else $error("generate item did not start at the first character");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (state_reg == rig_pkg::ST_IDLE))
        else $error("sequencer not idle after final character");
`endif

endmodule

### dv/tb_top.sv
// tb_top: self-checking bench for random_id_string_generator_core, seed mixing and id strings
// predicts each character from its own copy of the seed; needs rig_pkg and the core rtl only
module tb_top;

    localparam int          DIGITS      = 4;
    localparam int          GROUP       = 5;
    localparam logic [31:0] MULT        = 32'd1103515245;
    localparam logic [31:0] INCR        = 32'd12345;
    localparam logic [31:0] SEED_START  = 32'h0000_ACE1;
    localparam logic [7:0]  DASH        = 8'h2D;
    localparam logic [7:0]  DIGIT_BASE  = 8'h30;
    localparam int          IDLE_LIMIT  = 4000;
    localparam int          RAND_ITEMS  = 470;
    localparam int          NUM_PHASES  = 4;
    localparam int          SEND_IDLE [NUM_PHASES] = '{0, 47, 0, 9};
    localparam int          RECV_STALL[NUM_PHASES] = '{0, 0, 47, 9};
    // fixed three-letter prefix
    localparam logic [7:0]  ID_PREFIX [3] = '{8'h6C, 8'h64, 8'h6D};

    typedef struct {
        logic        operation;
        logic [31:0] entropy;
        int          phase;
        bit          hold;
    } stim_item_t;

    typedef struct {
        logic [7:0] character;
        logic       last;
    } id_char_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;              // [31:0] entropy
    logic        s_tuser  = rig_pkg::OP_MIX; // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;                    // [7:0] character
    logic        m_tlast;

    string       alnum_set = "abcdefghijklmnopqrstuvwxyz0123456789";
    logic [31:0] seed_copy = SEED_START;
    stim_item_t  pending_q[$];
    id_char_t    id_chars_q[$];
    stim_item_t  nxt;
    id_char_t    want;
    bit          busy;
    int          phase        = 0;
    int          mismatches   = 0;
    int          id_requests  = 0;
    int          seed_mixes   = 0;
    int          chars_seen   = 0;
    int          idle_cycles  = 0;
    bit          timed_out    = 1'b0;

    random_id_string_generator_core #(
        .DIGIT_COUNT (DIGITS),
        .GROUP_LENGTH(GROUP)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic logic [31:0] advance_seed();
        seed_copy = seed_copy * MULT + INCR;
        return seed_copy;
    endfunction

    function automatic void push_char(input logic [7:0] ch, input logic last);
        id_char_t c;
        c.character = ch;
        c.last      = last;
        id_chars_q.push_back(c);
    endfunction

    function automatic void predict_id();
        int k;
        for (k = 0; k < 3; k++) push_char(ID_PREFIX[k], 1'b0);
        for (k = 0; k < DIGITS; k++) push_char(DIGIT_BASE + 8'(advance_seed() % 10), 1'b0);
        push_char(DASH, 1'b0);
        for (k = 0; k < GROUP; k++) push_char(8'(alnum_set[advance_seed() % 36]), 1'b0);
        push_char(DASH, 1'b0);
        for (k = 0; k < GROUP; k++)
            push_char(8'(alnum_set[advance_seed() % 36]), k == GROUP - 1);
    endfunction

    function automatic void queue_item(input logic op, input logic [31:0] ent,
                                       input int ph, input bit hold);
        stim_item_t it;
        it.operation = op;
        it.entropy   = ent;
        it.phase     = ph;
        it.hold      = hold;
        pending_q.push_back(it);
    endfunction

    function automatic logic [31:0] random_entropy();
        logic [31:0] v;
        case ($urandom_range(5))
            0:       v = 32'h0;
            1:       v = 32'hFFFF_FFFF;
            2:       v = 32'h1 << $urandom_range(31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= rig_pkg::OP_MIX;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                busy = 1'b0;
                if (s_tuser == rig_pkg::OP_GENERATE) begin
                    id_requests++;
                    predict_id();
                end else begin
                    seed_mixes++;
                    seed_copy = seed_copy ^ s_tdata;
                end
            end
            if (!busy) begin
                if (pending_q.size() != 0 && !(pending_q[0].hold && id_chars_q.size() != 0)
                        && $urandom_range(99) >= SEND_IDLE[phase]) begin
                    nxt      = pending_q.pop_front();
                    phase    = nxt.phase;
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.entropy;
                    s_tuser  <= nxt.operation;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                chars_seen++;
                if (id_chars_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item char=%02h last=%0b",
                                              m_tdata, m_tlast));
                end else begin
                    want = id_chars_q.pop_front();
                    if (m_tdata !== want.character || m_tlast !== want.last)
                        report_mismatch($sformatf("char exp=%02h got=%02h last exp=%0b got=%0b",
                                                  want.character, m_tdata, want.last, m_tlast));
                end
            end
            m_tready <= ($urandom_range(99) >= RECV_STALL[phase]);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) timed_out <= 1'b1;
        end
    end

    initial begin
        int p;
        int n;

        // extremes, back-to-back mixes and back-to-back requests
        queue_item(rig_pkg::OP_GENERATE, 32'h0000_0000, 0, 1'b0);
        queue_item(rig_pkg::OP_GENERATE, 32'hFFFF_FFFF, 0, 1'b0);
        queue_item(rig_pkg::OP_MIX,      32'h0000_0000, 0, 1'b0);
        queue_item(rig_pkg::OP_GENERATE, 32'h0000_0000, 0, 1'b0);
        queue_item(rig_pkg::OP_MIX,      32'hFFFF_FFFF, 0, 1'b0);
        queue_item(rig_pkg::OP_GENERATE, 32'h1234_5678, 0, 1'b0);
        queue_item(rig_pkg::OP_MIX,      32'h5555_5555, 0, 1'b0);
        queue_item(rig_pkg::OP_MIX,      32'hAAAA_AAAA, 0, 1'b0);
        queue_item(rig_pkg::OP_GENERATE, 32'h0000_0000, 0, 1'b0);
        queue_item(rig_pkg::OP_MIX,      32'h0000_0001, 0, 1'b0);
        queue_item(rig_pkg::OP_GENERATE, 32'h0000_0000, 0, 1'b0);
        queue_item(rig_pkg::OP_MIX,      32'h8000_0000, 0, 1'b0);
        queue_item(rig_pkg::OP_GENERATE, 32'h0000_0000, 0, 1'b0);
        queue_item(rig_pkg::OP_MIX,      32'hFFFF_FFFF, 0, 1'b0);
        queue_item(rig_pkg::OP_MIX,      32'hFFFF_FFFF, 0, 1'b0);
        queue_item(rig_pkg::OP_GENERATE, 32'hFFFF_FFFF, 0, 1'b0);
        queue_item(rig_pkg::OP_GENERATE, 32'h0000_0000, 0, 1'b0);

        // random part, one stretch per idling phase, each opened after a full drain
        for (p = 0; p < NUM_PHASES; p++) begin
            for (n = 0; n < RAND_ITEMS / NUM_PHASES; n++) begin
                if ($urandom_range(99) < 60) begin
                    queue_item(rig_pkg::OP_GENERATE, $urandom, p, n == 0);
                end else begin
                    queue_item(rig_pkg::OP_MIX, random_entropy(), p, n == 0);
                end
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(negedge aclk);
        end while (!timed_out && !(pending_q.size() == 0 && !s_tvalid && id_chars_q.size() == 0));
        repeat (100) @(negedge aclk);

        if (timed_out) begin
            $display("tb_top failed");
            $finish;
        end else begin
            $display("run covered %0d id requests and %0d seed mixes, %0d characters checked",
                     id_requests, seed_mixes, chars_seen);
            $display("%0d mismatches, %0d characters never arrived", mismatches,
                     id_chars_q.size());
            if (mismatches == 0 && id_chars_q.size() == 0) begin
                $display("tb_top passed");
            end else begin
                $display("tb_top failed");
            end
            $finish;
        end
    end

endmodule
